@@ sv/gcpd_pkg.sv @@
// Shared types and constants for the Gray code pattern decoder.
package gcpd_pkg;

    localparam int MAX_PIXELS = 1048576;
    localparam int MAX_FRAMES = 64;

    localparam int POS_W   = $clog2(MAX_PIXELS);
    localparam int FILL_W  = POS_W + 1;
    localparam int PIX_W   = 8;
    localparam int CODE_W  = 64;
    localparam int BIT_W   = $clog2(CODE_W);
    localparam int FRM_W   = $clog2(MAX_FRAMES + 1);
    localparam int NPIX_W  = 21;
    localparam int THR_W   = 8;
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PIXELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b1;

    // Actions
    localparam logic ACT_PATTERN = 1'b0;
    localparam logic ACT_READOUT = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0]  lo;
        logic [PIX_W-1:0]  hi;
        logic [CODE_W-1:0] code;
    } t_cam;

    typedef struct packed {
        t_cam left;
        t_cam right;
    } t_entry;

    typedef struct packed {
        logic [CODE_W-1:0] code_left;
        logic [CODE_W-1:0] code_right;
        logic              valid_left;
        logic              valid_right;
        logic              last_pixel;
    } t_result;

    localparam int ENTRY_W  = $bits(t_entry);
    localparam int RESULT_W = $bits(t_result);

    localparam t_cam CAM_RESET = '{lo: {PIX_W{1'b1}}, hi: '0, code: '0};
    localparam t_entry ENTRY_RESET = '{left: CAM_RESET, right: CAM_RESET};

endpackage

@@ sv/gcpd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module gcpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/gcpd_update.sv @@
// Per-pixel modify step: min/max/code learning, readout decode and clear.
module gcpd_update (
    input  gcpd_pkg::t_entry                 i_entry,
    input  logic                             i_action,
    input  logic [gcpd_pkg::PIX_W-1:0]       i_pix_left,
    input  logic [gcpd_pkg::PIX_W-1:0]       i_pix_right,
    input  logic                             i_learn,
    input  logic [gcpd_pkg::BIT_W-1:0]       i_frame,
    input  logic [gcpd_pkg::THR_W-1:0]       i_threshold,
    input  logic                             i_last,
    output gcpd_pkg::t_entry                 o_entry,
    output gcpd_pkg::t_result                o_result
);
    import gcpd_pkg::*;

    function automatic t_cam learn_cam(t_cam cam, logic [PIX_W-1:0] v,
                                       logic [CODE_W-1:0] mask);
        t_cam            c;
        logic [PIX_W:0]  mid;
        c = cam;
        if (v < c.lo) c.lo = v;
        if (v > c.hi) c.hi = v;
        mid = ({1'b0, c.lo} + {1'b0, c.hi}) >> 1;
        if ({1'b0, v} > mid) c.code = c.code | mask;
        return c;
    endfunction

    function automatic logic [CODE_W-1:0] gray_decode(logic [CODE_W-1:0] g);
        logic [CODE_W-1:0] b;
        b = g;
        for (int k = 0; k < BIT_W; k++) begin
            b = b ^ (b >> (1 << k));
        end
        return b;
    endfunction

    function automatic logic contrast_ok(t_cam cam, logic [THR_W-1:0] thr);
        logic [PIX_W-1:0] diff;
        diff = cam.hi - cam.lo;
        return (cam.hi > cam.lo) && (diff > thr);
    endfunction

    logic [CODE_W-1:0] mask;

    assign mask = CODE_W'(1) << i_frame;

    // Build the written-back entry
    always_comb begin
        o_entry = i_entry;
        if (i_action == ACT_READOUT) begin
            o_entry = ENTRY_RESET;
        end else if (i_learn) begin
            o_entry.left  = learn_cam(i_entry.left, i_pix_left, mask);
            o_entry.right = learn_cam(i_entry.right, i_pix_right, mask);
        end
    end

    // Build the readout transaction from the stored entry
    always_comb begin
        o_result.code_left   = gray_decode(i_entry.left.code);
        o_result.code_right  = gray_decode(i_entry.right.code);
        o_result.valid_left  = contrast_ok(i_entry.left, i_threshold);
        o_result.valid_right = contrast_ok(i_entry.right, i_threshold);
        o_result.last_pixel  = i_last;
    end

endmodule

@@ sv/gcpd_out_queue.sv @@
// Two-entry output queue decoupling the pipeline from the result consumer.
module gcpd_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  gcpd_pkg::t_result i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output gcpd_pkg::t_result o_data,
    output logic [1:0]        o_count
);
    import gcpd_pkg::*;

    t_result    r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign pop     = (r_count != 2'd0) && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_q[r_rd_ptr];
    assign o_count = r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)    r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + 2'(i_push) - 2'(pop);
        end
    end

    // Store pushed transaction
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_data;
        end
    end

endmodule

@@ sv/gray_code_pattern_decoder.sv @@
// Gray code pattern decoder: one input transaction per cycle while o_in_ready is high.
// Each transaction reads its pixel entry in stage 0 and writes it back in stage 1;
// the pixel RAM, with one read and one write port, sets the rate of one transaction per cycle.
// Back-to-back accesses to the same pixel are forwarded from the last write.
// Reset is synchronous; a fill counter marks pixels never written since reset,
// which read as cleared, so no clearing sweep is needed and input is taken at once.
module gray_code_pattern_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [gcpd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [gcpd_pkg::NPIX_W-1:0]     i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_action,
    input  logic [gcpd_pkg::PIX_W-1:0]      i_pixel_left,
    input  logic [gcpd_pkg::PIX_W-1:0]      i_pixel_right,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [gcpd_pkg::CODE_W-1:0]     o_code_left,
    output logic [gcpd_pkg::CODE_W-1:0]     o_code_right,
    output logic                            o_valid_left,
    output logic                            o_valid_right,
    output logic                            o_last_pixel
);
    import gcpd_pkg::*;

    // Configuration
    logic [POS_W-1:0]  r_last_pos;
    logic [THR_W-1:0]  r_threshold;
    logic [31:0]       cfg_limit;

    // Stage 0 control
    logic [POS_W-1:0]  r_pos;
    logic [FRM_W-1:0]  r_frames;
    logic [FILL_W-1:0] r_fill;
    logic [POS_W-1:0]  cur_pos;
    logic              cur_last;
    logic              accept;

    // Stage 1
    logic              r_s1_valid;
    logic              r_s1_fwd;
    logic              r_s1_action;
    logic [PIX_W-1:0]  r_s1_pix_left;
    logic [PIX_W-1:0]  r_s1_pix_right;
    logic [POS_W-1:0]  r_s1_addr;
    logic              r_s1_last;
    logic              r_s1_learn;
    logic [BIT_W-1:0]  r_s1_frame;
    logic              r_s1_hit;
    t_entry            r_fwd_entry;

    t_entry            ram_rdata;
    t_entry            s1_entry;
    t_entry            n_entry;
    t_result           s1_result;
    logic              s1_push;

    // Output queue
    t_result           q_data;
    logic [1:0]        q_count;
    logic              q_pop;
    logic [2:0]        q_next;

    // Clamp the pixel count and hold the threshold
    always_comb begin
        cfg_limit = 32'(i_cfg_data);
        if (cfg_limit == 32'd0) begin
            cfg_limit = 32'd1;
        end else if (cfg_limit > 32'(MAX_PIXELS)) begin
            cfg_limit = 32'(MAX_PIXELS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos  <= POS_W'(MAX_PIXELS - 1);
            r_threshold <= THR_W'(1);
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_NUM_PIXELS) begin
                r_last_pos <= POS_W'(cfg_limit - 32'd1);
            end else if (i_cfg_index == CFG_THRESHOLD) begin
                r_threshold <= i_cfg_data[THR_W-1:0];
            end
        end
    end

    // Stage 0: current position and frame-end detection
    assign cur_pos  = (FILL_W'(r_pos) >= FILL_W'(MAX_PIXELS)) ? '0 : r_pos;
    assign cur_last = (cur_pos >= r_last_pos);

    // Hold input while the queue could not absorb an in-flight result
    assign q_pop      = o_out_valid && i_out_ready;
    assign q_next     = 3'(q_count) + 3'(s1_push) - 3'(q_pop);
    assign o_in_ready = (q_next <= 3'd1);
    assign accept     = i_in_valid && o_in_ready;

    // Advance position, frame count and fill mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_frames <= '0;
            r_fill   <= '0;
        end else if (accept) begin
            r_pos <= cur_last ? '0 : POS_W'(cur_pos + POS_W'(1));
            if (i_action == ACT_READOUT) begin
                if (cur_last) r_frames <= '0;
            end else if (cur_last && (r_frames < FRM_W'(MAX_FRAMES))) begin
                r_frames <= r_frames + FRM_W'(1);
            end
            if (FILL_W'(cur_pos) >= r_fill) begin
                r_fill <= FILL_W'(cur_pos) + FILL_W'(1);
            end
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_s1_fwd   <= accept && r_s1_valid && (r_s1_addr == cur_pos);
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action    <= i_action;
            r_s1_pix_left  <= i_pixel_left;
            r_s1_pix_right <= i_pixel_right;
            r_s1_addr      <= cur_pos;
            r_s1_last      <= cur_last;
            r_s1_learn     <= (r_frames < FRM_W'(MAX_FRAMES));
            r_s1_frame     <= r_frames[BIT_W-1:0];
            r_s1_hit       <= (FILL_W'(cur_pos) < r_fill);
        end
        if (r_s1_valid) begin
            r_fwd_entry <= n_entry;
        end
    end

    gcpd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PIXELS)
    ) u_pixel_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry),
        .i_re    (accept),
        .i_raddr (cur_pos),
        .o_rdata (ram_rdata)
    );

    // Select the entry: last write, stored data, or cleared value
    always_comb begin
        priority if (r_s1_fwd) begin
            s1_entry = r_fwd_entry;
        end else if (r_s1_hit) begin
            s1_entry = ram_rdata;
        end else begin
            s1_entry = ENTRY_RESET;
        end
    end

    gcpd_update u_update (
        .i_entry     (s1_entry),
        .i_action    (r_s1_action),
        .i_pix_left  (r_s1_pix_left),
        .i_pix_right (r_s1_pix_right),
        .i_learn     (r_s1_learn),
        .i_frame     (r_s1_frame),
        .i_threshold (r_threshold),
        .i_last      (r_s1_last),
        .o_entry     (n_entry),
        .o_result    (s1_result)
    );

    assign s1_push = r_s1_valid && (r_s1_action == ACT_READOUT);

    gcpd_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s1_push),
        .i_data  (s1_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_code_left   = q_data.code_left;
    assign o_code_right  = q_data.code_right;
    assign o_valid_left  = q_data.valid_left;
    assign o_valid_right = q_data.valid_right;
    assign o_last_pixel  = q_data.last_pixel;

`ifndef SYNTHESIS
    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_push |-> (q_count != 2'd2) || q_pop)
        else $error("output queue overflow");

    a_frames_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames <= FRM_W'(MAX_FRAMES))
        else $error("frame count beyond limit");

    a_fwd_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> r_s1_valid)
        else $error("forwarding without a stage 1 transaction");

    a_fwd_same_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_fwd |-> (r_s1_addr == $past(r_s1_addr)))
        else $error("forwarding between different pixels");
`endif

endmodule

@@ verif/tb.sv @@
// Testbench for the Gray code pattern decoder: directed rows, then random pixel scans.
module tb;
    import gcpd_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 450;
    localparam int BURST_ITEMS    = 40;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [NPIX_W-1:0]    reg_val;
        logic                 act;
        logic [PIX_W-1:0]     pl;
        logic [PIX_W-1:0]     pr;
        bit                   checked;
        t_result              want;
    } t_dir_row;

    localparam t_result BLANK = '0;
    localparam t_result BLANK_LAST = '{code_left: '0, code_right: '0, valid_left: 1'b0,
                                       valid_right: 1'b0, last_pixel: 1'b1};

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [NPIX_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 action;
    logic [PIX_W-1:0]     pixel_left;
    logic [PIX_W-1:0]     pixel_right;
    logic                 out_valid;
    logic                 out_ready;
    logic [CODE_W-1:0]    code_left;
    logic [CODE_W-1:0]    code_right;
    logic                 valid_left;
    logic                 valid_right;
    logic                 last_pixel;

    // Predictor state: pixels absent from the store hold their reset values
    t_entry            pix_store [int unsigned];
    logic [NPIX_W-1:0] npix_cfg;
    logic [THR_W-1:0]  thr_cfg;
    int unsigned       raster_pos;
    int unsigned       frame_count;
    t_result           pending_codes [$];

    t_dir_row    dir_rows [$];
    bit          calm;
    bit          hold_req;
    int unsigned items_sent;
    int unsigned fail_cnt;
    int unsigned stall_cycles;

    gray_code_pattern_decoder dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_action      (action),
        .i_pixel_left  (pixel_left),
        .i_pixel_right (pixel_right),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_code_left   (code_left),
        .o_code_right  (code_right),
        .o_valid_left  (valid_left),
        .o_valid_right (valid_right),
        .o_last_pixel  (last_pixel)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Gray to binary: each binary bit is the XOR of all Gray bits at and above it
    function automatic logic [CODE_W-1:0] gray_to_bin(input logic [CODE_W-1:0] g);
        logic [CODE_W-1:0] b;
        b = g;
        for (int i = CODE_W - 2; i >= 0; i--)
            b[i] = b[i+1] ^ g[i];
        return b;
    endfunction

    // Widen min/max, then set the frame bit when above the midpoint
    function automatic t_cam train_cam(input t_cam c, input logic [PIX_W-1:0] v,
                                       input int unsigned bit_no);
        int unsigned mid;
        if (v < c.lo) c.lo = v;
        if (v > c.hi) c.hi = v;
        mid = (int'(c.lo) + int'(c.hi)) / 2;
        if (v > mid) c.code[bit_no] = 1'b1;
        return c;
    endfunction

    function automatic logic has_contrast(input logic [PIX_W-1:0] lo, input logic [PIX_W-1:0] hi);
        return (hi > lo) && ((hi - lo) > thr_cfg);
    endfunction

    // Advance the pixel model by one transaction; returns 1 when a result is due
    function automatic bit track_pixel(input logic act, input logic [PIX_W-1:0] pl,
                                       input logic [PIX_W-1:0] pr, output t_result res);
        int unsigned lim;
        int unsigned p;
        bit          at_end;
        bit          emits;
        t_entry      e;
        lim = npix_cfg;
        if (lim < 1) lim = 1;
        if (lim > MAX_PIXELS) lim = MAX_PIXELS;
        p = raster_pos;
        if (p >= MAX_PIXELS) p = 0;
        at_end = (p + 1 >= lim);
        e = pix_store.exists(p) ? pix_store[p] : ENTRY_RESET;
        emits = 1'b0;
        res = BLANK;
        if (act == ACT_PATTERN) begin
            // frames past the limit leave the pixel untouched
            if (frame_count < MAX_FRAMES) begin
                e.left  = train_cam(e.left, pl, frame_count);
                e.right = train_cam(e.right, pr, frame_count);
                pix_store[p] = e;
                if (at_end) frame_count++;
            end
        end else begin
            res.code_left   = gray_to_bin(e.left.code);
            res.code_right  = gray_to_bin(e.right.code);
            res.valid_left  = has_contrast(e.left.lo, e.left.hi);
            res.valid_right = has_contrast(e.right.lo, e.right.hi);
            res.last_pixel  = at_end;
            pix_store.delete(p);
            if (at_end) frame_count = 0;
            emits = 1'b1;
        end
        raster_pos = at_end ? 0 : p + 1;
        return emits;
    endfunction

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 21);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [NPIX_W-1:0] val);
        t_dir_row r;
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        r.checked = 1'b0;
        dir_rows  = {dir_rows, r};
    endfunction

    function automatic void add_checked(input logic act, input logic [PIX_W-1:0] pl,
                                        input logic [PIX_W-1:0] pr, input bit checked,
                                        input t_result want);
        t_dir_row r;
        r.kind    = ROW_ITEM;
        r.act     = act;
        r.pl      = pl;
        r.pr      = pr;
        r.checked = checked;
        r.want    = want;
        dir_rows  = {dir_rows, r};
    endfunction

    function automatic void add_item(input logic act, input logic [PIX_W-1:0] pl,
                                     input logic [PIX_W-1:0] pr);
        add_checked(act, pl, pr, 1'b0, BLANK);
    endfunction

    // Offer one transaction, hold it until accepted, then record its expected result
    task automatic send_item(input logic act, input logic [PIX_W-1:0] pl,
                             input logic [PIX_W-1:0] pr, input bit checked,
                             input t_result want);
        t_result res;
        @(negedge clk);
        while (take_break()) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        pixel_left  <= pl;
        pixel_right <= pr;
        do @(posedge clk); while (!in_ready);
        if (track_pixel(act, pl, pr, res))
            pending_codes = {pending_codes, (checked ? want : res)};
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NPIX_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_NUM_PIXELS)
            npix_cfg = val;
        else
            thr_cfg = val[THR_W-1:0];
    endtask

    // Drop valid, wait for every expected result, then let the pipeline settle
    task automatic drain(input int extra);
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_codes.size() != 0) @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_ready <= !take_break();
            end
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin : check_out
        t_result got;
        t_result want;
        if (rst_n && out_valid && out_ready) begin
            got = '{code_left: code_left, code_right: code_right, valid_left: valid_left,
                    valid_right: valid_right, last_pixel: last_pixel};
            if (pending_codes.size() == 0) begin
                $error("unexpected result transaction: code_left %h code_right %h",
                       got.code_left, got.code_right);
                fail_cnt++;
            end else begin
                want = pending_codes.pop_front();
                if (got.code_left !== want.code_left) begin
                    $error("code_left: expected %h, got %h", want.code_left, got.code_left);
                    fail_cnt++;
                end
                if (got.code_right !== want.code_right) begin
                    $error("code_right: expected %h, got %h", want.code_right, got.code_right);
                    fail_cnt++;
                end
                if (got.valid_left !== want.valid_left) begin
                    $error("valid_left: expected %b, got %b", want.valid_left, got.valid_left);
                    fail_cnt++;
                end
                if (got.valid_right !== want.valid_right) begin
                    $error("valid_right: expected %b, got %b", want.valid_right,
                           got.valid_right);
                    fail_cnt++;
                end
                if (got.last_pixel !== want.last_pixel) begin
                    $error("last_pixel: expected %b, got %b", want.last_pixel, got.last_pixel);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        logic [NPIX_W-1:0] np;
        logic [NPIX_W-1:0] thr_word;
        int unsigned       frames;
        int unsigned       span;
        int unsigned       rd;
        int unsigned       phase;

        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_NUM_PIXELS;
        cfg_data    = '0;
        in_valid    = 1'b0;
        action      = ACT_PATTERN;
        pixel_left  = '0;
        pixel_right = '0;
        npix_cfg    = NPIX_W'(MAX_PIXELS);
        thr_cfg     = THR_W'(1);
        raster_pos  = 0;
        frame_count = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        items_sent  = 0;
        fail_cnt    = 0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Reset configuration: readouts of pixels never written are blank
        add_checked(ACT_READOUT, 8'h5A, 8'hA5, 1'b1, BLANK);
        add_item(ACT_PATTERN, 8'h00, 8'hFF);
        add_item(ACT_PATTERN, 8'hFF, 8'h00);
        add_checked(ACT_READOUT, 8'h00, 8'h00, 1'b1, BLANK);
        // Zero pixel count acts as one; position already lies past the frame
        add_cfg(CFG_NUM_PIXELS, '0);
        add_item(ACT_PATTERN, 8'hFF, 8'hFF);
        add_checked(ACT_READOUT, 8'hFF, 8'hFF, 1'b1, BLANK_LAST);
        // Single pixel, zero threshold: several frames then readout
        add_cfg(CFG_THRESHOLD, '0);
        add_item(ACT_PATTERN, 8'h00, 8'h00);
        add_item(ACT_PATTERN, 8'hFF, 8'hFF);
        add_item(ACT_PATTERN, 8'h80, 8'h7F);
        add_item(ACT_READOUT, 8'h00, 8'h00);
        // Oversized pixel count clamps; threshold 255 never passes
        add_cfg(CFG_NUM_PIXELS, '1);
        add_cfg(CFG_THRESHOLD, '1);
        add_item(ACT_PATTERN, 8'h00, 8'hFF);
        add_item(ACT_PATTERN, 8'hFF, 8'h00);
        add_checked(ACT_READOUT, 8'hFF, 8'hFF, 1'b1, BLANK);
        // Shrink the frame below the position: next transaction is the last pixel
        add_cfg(CFG_NUM_PIXELS, NPIX_W'(2));
        add_checked(ACT_READOUT, 8'h00, 8'hFF, 1'b1, BLANK_LAST);
        add_item(ACT_READOUT, 8'h00, 8'h00);
        add_item(ACT_READOUT, 8'h00, 8'h00);
        add_cfg(CFG_NUM_PIXELS, NPIX_W'(1));
        add_cfg(CFG_THRESHOLD, '0);
        add_item(ACT_PATTERN, 8'h00, 8'h00);
        add_item(ACT_PATTERN, 8'hFF, 8'hFF);
        add_item(ACT_READOUT, 8'h00, 8'h00);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain(SETTLE_CYCLES);
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
            end else begin
                send_item(dir_rows[i].act, dir_rows[i].pl, dir_rows[i].pr,
                          dir_rows[i].checked, dir_rows[i].want);
            end
        end

        // Random scans: mostly pattern frames over a small frame, then a readout pass
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            drain(SETTLE_CYCLES);
            calm   = (phase == 3);
            frames = 0;
            if (phase == 0) begin
                np     = NPIX_W'(1);
                frames = 66;
            end else if (phase == 1) begin
                np = NPIX_W'(16);
            end else if (phase == 3) begin
                // long scan with no idling on either side
                np     = NPIX_W'(8);
                frames = 6;
            end else if ($urandom_range(9) == 0) begin
                case ($urandom_range(3))
                    0:       np = NPIX_W'(MAX_PIXELS);
                    1:       np = '1;
                    2:       np = NPIX_W'(MAX_PIXELS + 1 + $urandom_range(1000));
                    default: np = NPIX_W'($urandom_range(MAX_PIXELS - 1, 17));
                endcase
            end else begin
                np = ($urandom_range(15) == 0) ? '0 : NPIX_W'($urandom_range(8, 1));
                if (np <= 2 && $urandom_range(4) == 0)
                    frames = $urandom_range(66, 63);
                else
                    frames = $urandom_range(6);
            end
            thr_word = NPIX_W'($urandom_range(2 ** NPIX_W - 1));
            case ($urandom_range(3))
                0:       thr_word[THR_W-1:0] = '0;
                1:       thr_word[THR_W-1:0] = '1;
                default: ;
            endcase
            write_reg(CFG_NUM_PIXELS, np);
            write_reg(CFG_THRESHOLD, thr_word);

            if (phase == 1) begin
                // Hold off the receiver so the block fills and stalls its input
                hold_req = 1'b1;
                for (int k = 0; k < BURST_ITEMS; k++) begin
                    if (k == BURST_ITEMS / 2) drain(0);
                    send_item(ACT_READOUT, PIX_W'($urandom_range(255)),
                              PIX_W'($urandom_range(255)), 1'b0, BLANK);
                end
            end else if (np > 16) begin
                repeat (12)
                    send_item(1'($urandom_range(1)), PIX_W'($urandom_range(255)),
                              PIX_W'($urandom_range(255)), 1'b0, BLANK);
            end else begin
                span = (np == 0) ? 1 : np;
                for (int f = 0; f < frames; f++) begin
                    for (int k = 0; k < span; k++) begin
                        // stray transaction that breaks the frame alignment
                        if ($urandom_range(99) < 8)
                            send_item(1'($urandom_range(1)), PIX_W'($urandom_range(255)),
                                      PIX_W'($urandom_range(255)), 1'b0, BLANK);
                        send_item(ACT_PATTERN, PIX_W'($urandom_range(255)),
                                  PIX_W'($urandom_range(255)), 1'b0, BLANK);
                    end
                end
                rd = ($urandom_range(9) == 0) ? $urandom_range(span) : span;
                repeat (rd)
                    send_item(ACT_READOUT, PIX_W'($urandom_range(255)),
                              PIX_W'($urandom_range(255)), 1'b0, BLANK);
            end
            phase++;
        end

        drain(SETTLE_CYCLES + 2);
        if (fail_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/gcpd_pkg.sv
sv/gcpd_ram.sv
sv/gcpd_update.sv
sv/gcpd_out_queue.sv
sv/gray_code_pattern_decoder.sv
verif/tb.sv
